// File: rtl/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
// Command codes, control states, character codes and register indexes.
// No dependencies.
package tccw_pkg;

	typedef enum logic [2:0] {
		CMD_PUT_CUR  = 3'd0,
		CMD_PUT_CELL = 3'd1,
		CMD_SET_CUR  = 3'd2,
		CMD_MOVE_CUR = 3'd3,
		CMD_CLEAR    = 3'd4,
		CMD_READ     = 3'd5
	} cmd_t;

	typedef enum logic {
		ST_SWEEP = 1'b0,
		ST_RUN   = 1'b1
	} state_t;

	localparam logic [1:0]  REG_FG     = 2'd0;
	localparam logic [1:0]  REG_BG     = 2'd1;

	localparam logic [7:0]  CH_LF      = 8'h0A;
	localparam logic [7:0]  CH_CR      = 8'h0D;
	localparam logic [7:0]  CH_TAB     = 8'h09;
	localparam logic [7:0]  CH_SPACE   = 8'h20;
	localparam logic [7:0]  TAB_STOP   = 8'd8;
	localparam logic [7:0]  TAB_MASK   = 8'hF8;

	localparam logic [15:0] RESET_CELL = 16'h0F20;
	localparam logic [3:0]  RESET_FG   = 4'hF;
	localparam logic [3:0]  RESET_BG   = 4'h0;

endpackage

// File: rtl/text_console_cell_writer_top.sv
// Text console cell writer: screen store, cursor and command decoder.
// Results pass stage 1, then the stage 2 register; one command per cycle when unstalled.
// Clear walks every cell, one per cycle, and no command is taken until the sweep ends.
// After reset the same sweep writes 16'h0F20 to every cell.
// Cursor resets home, colours to 15 on 0; the screen store itself has no reset.
// Depends on tccw_pkg.
module text_console_cell_writer_top import tccw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [3:0]        wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        cmd,
	input  logic [7:0]        ch,
	input  logic [7:0]        col,
	input  logic [7:0]        row,
	input  logic signed [7:0] col_step,
	input  logic signed [7:0] row_step,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [6:0]        cur_col,
	output logic [4:0]        cur_row,
	output logic [10:0]       cursor_offset,
	output logic [15:0]       read_cell,
	output logic              applied
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int OW    = (AW > 11) ? AW : 11;

	// control and configuration
	state_t          state_q, state_nxt;
	logic [AW-1:0]   cnt_q;
	logic [15:0]     fill_q;
	logic [3:0]      fg_q, bg_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic            sweep;
	logic            acc;
	logic            move;

	// screen store
	logic [15:0]     mem [CELLS];
	logic [15:0]     rdata_q;
	logic            mem_we, mem_re;
	logic [AW-1:0]   mem_wa, mem_ra;
	logic [15:0]     mem_wd;

	// command decode
	logic [7:0]      col_w, col_inc, tab_col;
	logic [RW-1:0]   row_down;
	logic [OW-1:0]   in_addr, cur_addr;
	logic signed [9:0] tgt_c, tgt_r;
	logic            tgt_ok, in_ok;
	logic [CW-1:0]   nxt_col;
	logic [RW-1:0]   nxt_row;
	logic            nxt_app, cmd_wr, cmd_rd;
	logic [AW-1:0]   cmd_wa;
	logic [7:0]      cmd_ch;
	logic [7:0]      attr;

	// stage 1: cursor result, memory read in flight
	logic            valid_s1, rd_s1, app_s1;
	logic [CW-1:0]   col_s1;
	logic [RW-1:0]   row_s1;
	logic [OW-1:0]   ofs_s1;

	// stage 2: result register
	logic            valid_s2, app_s2;
	logic [CW-1:0]   col_s2;
	logic [RW-1:0]   row_s2;
	logic [OW-1:0]   ofs_s2;
	logic [15:0]     rd_s2;

	// ---------------- state machine ----------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_SWEEP: begin
				if (cnt_q == AW'(CELLS - 1)) state_nxt = ST_RUN;
			end
			ST_RUN: begin
				if (acc && cmd_t'(cmd) == CMD_CLEAR) state_nxt = ST_SWEEP;
			end
			default: state_nxt = ST_RUN;
		endcase
	end

	always_comb begin
		sweep    = (state_q == ST_SWEEP);
		move     = valid_s1 && (!valid_s2 || out_ready);
		in_ready = !sweep && (!valid_s1 || move);
		acc      = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			cnt_q   <= '0;
			fill_q  <= RESET_CELL;
		end else begin
			state_q <= state_nxt;
			if (sweep) begin
				cnt_q <= (cnt_q == AW'(CELLS - 1)) ? '0 : cnt_q + AW'(1);
			end
			// latch the blank cell with the attribute in force when the clear is taken
			if (acc && cmd_t'(cmd) == CMD_CLEAR) fill_q <= {attr, CH_SPACE};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= RESET_FG;
			bg_q <= RESET_BG;
		end else if (wr_en) begin
			if (wr_index == REG_FG) fg_q <= wr_data;
			if (wr_index == REG_BG) bg_q <= wr_data;
		end
	end

	// ---------------- command decode ----------------
	always_comb begin
		attr     = {bg_q, fg_q};
		col_w    = 8'(col_q);
		col_inc  = col_w + 8'd1;
		tab_col  = (col_w + TAB_STOP) & TAB_MASK;
		row_down = (row_q == RW'(ROWS - 1)) ? row_q : row_q + RW'(1);
		in_addr  = OW'(row) * OW'(COLUMNS) + OW'(col);
		cur_addr = OW'(row_q) * OW'(COLUMNS) + OW'(col_q);
		in_ok    = (col < 8'(COLUMNS)) && (row < 8'(ROWS));

		if (cmd_t'(cmd) == CMD_MOVE_CUR) begin
			tgt_c = signed'({2'b00, col_w}) + 10'(col_step);
			tgt_r = signed'({2'b00, 8'(row_q)}) + 10'(row_step);
		end else begin
			tgt_c = signed'({2'b00, col});
			tgt_r = signed'({2'b00, row});
		end
		tgt_ok = (tgt_c >= 10'sd0) && (tgt_c < 10'(COLUMNS))
			&& (tgt_r >= 10'sd0) && (tgt_r < 10'(ROWS));

		nxt_col = col_q;
		nxt_row = row_q;
		nxt_app = 1'b0;
		cmd_wr  = 1'b0;
		cmd_rd  = 1'b0;
		cmd_wa  = in_addr[AW-1:0];
		cmd_ch  = ch;

		case (cmd_t'(cmd))
			CMD_PUT_CUR: begin
				cmd_wa = cur_addr[AW-1:0];
				if (ch == CH_LF) begin
					nxt_col = '0;
					nxt_row = row_down;
					nxt_app = 1'b1;
				end else if (ch == CH_CR) begin
					nxt_col = '0;
					nxt_app = 1'b1;
				end else if (ch == CH_TAB) begin
					nxt_app = 1'b1;
					if (tab_col >= 8'(COLUMNS)) begin
						nxt_col = '0;
						nxt_row = row_down;
					end else begin
						nxt_col = tab_col[CW-1:0];
					end
				end else if (!ch[7] && ch >= CH_SPACE) begin
					cmd_wr  = 1'b1;
					nxt_app = 1'b1;
					if (col_inc >= 8'(COLUMNS)) begin
						nxt_col = '0;
						nxt_row = row_down;
					end else begin
						nxt_col = col_inc[CW-1:0];
					end
				end
			end
			CMD_PUT_CELL: begin
				cmd_wr  = in_ok;
				nxt_app = in_ok;
			end
			CMD_SET_CUR, CMD_MOVE_CUR: begin
				if (tgt_ok) begin
					nxt_col = tgt_c[CW-1:0];
					nxt_row = tgt_r[RW-1:0];
					nxt_app = 1'b1;
				end
			end
			CMD_CLEAR: begin
				nxt_col = '0;
				nxt_row = '0;
				nxt_app = 1'b1;
			end
			CMD_READ: begin
				cmd_rd  = in_ok;
				nxt_app = in_ok;
			end
			default: begin
				nxt_app = 1'b0;
			end
		endcase
	end

	// ---------------- screen store ----------------
	always_comb begin
		mem_we = sweep || (acc && cmd_wr);
		mem_wa = sweep ? cnt_q : cmd_wa;
		mem_wd = sweep ? fill_q : {attr, cmd_ch};
		mem_re = acc && cmd_rd;
		mem_ra = in_addr[AW-1:0];
	end

	// read data holds until the next read, so a stalled stage 1 keeps its cell
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rdata_q <= mem[mem_ra];
	end

	// ---------------- cursor and pipeline ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (acc) begin
				col_q <= nxt_col;
				row_q <= nxt_row;
			end
			if (acc) valid_s1 <= 1'b1;
			else if (move) valid_s1 <= 1'b0;
			if (move) valid_s2 <= 1'b1;
			else if (out_ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1 <= nxt_col;
			row_s1 <= nxt_row;
			rd_s1  <= cmd_rd;
			app_s1 <= nxt_app;
		end
		if (move) begin
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			ofs_s2 <= ofs_s1;
			app_s2 <= app_s1;
			rd_s2  <= rd_s1 ? rdata_q : 16'h0000;
		end
	end

	assign ofs_s1 = OW'(row_s1) * OW'(COLUMNS) + OW'(col_s1);

	assign out_valid     = valid_s2;
	assign cur_col       = 7'(col_s2);
	assign cur_row       = 5'(row_s2);
	assign cursor_offset = ofs_s2[10:0];
	assign read_cell     = rd_s2;
	assign applied       = app_s2;

	// ---------------- assertions ----------------
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q < CW'(COLUMNS - 1) || col_q == CW'(COLUMNS - 1))
		&& (row_q < RW'(ROWS - 1) || row_q == RW'(ROWS - 1)))
		else $error("cursor left the screen");

	a_clear_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd_t'(cmd) == CMD_CLEAR |=> sweep && cnt_q == '0)
		else $error("clear did not start a sweep from the first cell");

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		sweep |-> !valid_s1 || !rd_s1 || $stable(rdata_q))
		else $error("read data disturbed during sweep");

	a_read_only_applied: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_cell != 16'h0000 |-> applied)
		else $error("cell data returned for an ignored command");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !move |=> valid_s1 && $stable(col_s1) && $stable(row_s1))
		else $error("stage 1 result lost while stalled");

endmodule

// File: tb/tb_text_console_cell_writer_top.sv
// Testbench for text_console_cell_writer_top: directed and random console commands
// checked against a cycle-free model of the screen, cursor and colour registers.
// Depends on tccw_pkg and the RTL of the block.
module tb_text_console_cell_writer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tccw_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;
	localparam logic [1:0] REG_SPARE2 = 2'd2;
	localparam logic [1:0] REG_SPARE3 = 2'd3;

	typedef struct packed {
		logic [6:0]  col;
		logic [4:0]  row;
		logic [10:0] offset;
		logic [15:0] cell_val;
		logic        ok;
	} console_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [3:0]  wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  cmd;
	logic [7:0]  ch;
	logic [7:0]  col;
	logic [7:0]  row;
	logic [7:0]  col_step;
	logic [7:0]  row_step;
	logic        out_valid;
	logic        out_ready;
	logic [6:0]  cur_col;
	logic [4:0]  cur_row;
	logic [10:0] cursor_offset;
	logic [15:0] read_cell;
	logic        applied;

	// screen and cursor as the block should hold them
	logic [15:0] screen [CELLS];
	int          cur_c;
	int          cur_r;
	logic [3:0]  fg;
	logic [3:0]  bg;

	console_result_t pending_results[$];

	int mismatches = 0;
	int n_cmds     = 0;
	int n_clears   = 0;
	int n_writes   = 0;
	int n_checked  = 0;
	int gap_pct    = 0;
	int stall_pct  = 0;
	int stall_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_console_cell_writer_top #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.ch(ch),
		.col(col),
		.row(row),
		.col_step(col_step),
		.row_step(row_step),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cur_col(cur_col),
		.cur_row(cur_row),
		.cursor_offset(cursor_offset),
		.read_cell(read_cell),
		.applied(applied)
	);

	function automatic logic [15:0] cell_of(logic [7:0] chr);
		return {bg, fg, chr};
	endfunction

	function automatic bit on_screen(int c, int r);
		return c >= 0 && c < COLUMNS && r >= 0 && r < ROWS;
	endfunction

	function automatic console_result_t console_apply(logic [2:0] op, logic [7:0] chr,
			logic [7:0] c8, logic [7:0] r8, logic [7:0] dc, logic [7:0] dr);
		console_result_t res;
		int c;
		int r;
		res = '0;
		c = int'(c8);
		r = int'(r8);
		case (op)
			CMD_PUT_CUR: begin
				res.ok = 1'b1;
				if (chr == CH_LF) begin
					cur_c = 0;
					if (cur_r < ROWS - 1)
						cur_r++;
				end else if (chr == CH_CR) begin
					cur_c = 0;
				end else if (chr == CH_TAB) begin
					cur_c = (cur_c + int'(TAB_STOP)) & ~(int'(TAB_STOP) - 1);
				end else if (chr >= CH_SPACE && !chr[7]) begin
					screen[cur_r * COLUMNS + cur_c] = cell_of(chr);
					cur_c++;
				end else begin
					res.ok = 1'b0;
				end
				// wrap at the line end, hold on the bottom row
				if (cur_c >= COLUMNS) begin
					cur_c = 0;
					if (cur_r < ROWS - 1)
						cur_r++;
				end
			end
			CMD_PUT_CELL: begin
				if (on_screen(c, r)) begin
					screen[r * COLUMNS + c] = cell_of(chr);
					res.ok = 1'b1;
				end
			end
			CMD_SET_CUR, CMD_MOVE_CUR: begin
				if (op == CMD_MOVE_CUR) begin
					c = cur_c + int'($signed(dc));
					r = cur_r + int'($signed(dr));
				end
				if (on_screen(c, r)) begin
					cur_c = c;
					cur_r = r;
					res.ok = 1'b1;
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen[i] = cell_of(CH_SPACE);
				cur_c = 0;
				cur_r = 0;
				res.ok = 1'b1;
			end
			CMD_READ: begin
				if (on_screen(c, r)) begin
					res.cell_val = screen[r * COLUMNS + c];
					res.ok = 1'b1;
				end
			end
			default: ;
		endcase
		res.col = cur_c[6:0];
		res.row = cur_r[4:0];
		res.offset = 11'(cur_r * COLUMNS + cur_c);
		return res;
	endfunction

	// result checker
	always @(posedge clk) begin
		console_result_t got;
		console_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {cur_col, cur_row, cursor_offset, read_cell, applied};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t: result with nothing pending: col %0d row %0d off %0d %s",
						$realtime, got.col, got.row, got.offset,
						$sformatf("cell %h ok %b", got.cell_val, got.ok));
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%t: result %0d: want col %0d row %0d off %0d cell %h ok %b",
							$realtime, n_checked, want.col, want.row, want.offset,
							want.cell_val, want.ok);
						$display("%t: result %0d: got  col %0d row %0d off %0d cell %h ok %b",
							$realtime, n_checked, got.col, got.row, got.offset,
							got.cell_val, got.ok);
					end
				end
			end
		end
	end

	// result side back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_cmd(logic [2:0] op, logic [7:0] chr, logic [7:0] c8, logic [7:0] r8,
			logic [7:0] dc, logic [7:0] dr);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		ch <= chr;
		col <= c8;
		row <= r8;
		col_step <= dc;
		row_step <= dr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(console_apply(op, chr, c8, r8, dc, dr));
		n_cmds++;
		if (op == CMD_CLEAR)
			n_clears++;
	endtask

	task automatic put_ch(logic [7:0] chr);
		send_cmd(CMD_PUT_CUR, chr, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic put_cell(logic [7:0] c8, logic [7:0] r8, logic [7:0] chr);
		send_cmd(CMD_PUT_CELL, chr, c8, r8, 8'($urandom), 8'($urandom));
	endtask

	task automatic set_cursor(logic [7:0] c8, logic [7:0] r8);
		send_cmd(CMD_SET_CUR, 8'($urandom), c8, r8, 8'($urandom), 8'($urandom));
	endtask

	task automatic move_cursor(logic [7:0] dc, logic [7:0] dr);
		send_cmd(CMD_MOVE_CUR, 8'($urandom), 8'($urandom), 8'($urandom), dc, dr);
	endtask

	task automatic read_at(logic [7:0] c8, logic [7:0] r8);
		send_cmd(CMD_READ, 8'($urandom), c8, r8, 8'($urandom), 8'($urandom));
	endtask

	task automatic send_any(logic [2:0] op);
		send_cmd(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// drop valid, drain every result and let a clear sweep finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [3:0] val);
		wait_idle();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_FG)
			fg = val;
		else if (idx == REG_BG)
			bg = val;
		n_writes++;
	endtask

	task automatic set_colours(logic [3:0] f, logic [3:0] b);
		write_reg(REG_FG, f);
		write_reg(REG_BG, b);
	endtask

	task automatic test_reset_screen();
		wait_idle();
		read_at(8'd0, 8'd0);
		read_at(8'(COLUMNS - 1), 8'(ROWS - 1));
		read_at(8'(COLUMNS), 8'd0);
		read_at(8'hFF, 8'hFF);
	endtask

	task automatic test_put_at_cursor();
		put_ch(8'h41);
		put_ch(CH_SPACE);
		put_ch(8'h7F);
		put_ch(8'hFF);
		put_ch(8'h00);
		put_ch(CH_TAB);
		put_ch(CH_CR);
		put_ch(CH_LF);
	endtask

	task automatic test_cells_and_cursor();
		put_cell(8'(COLUMNS - 1), 8'(ROWS - 1), 8'hFF);
		put_cell(8'(COLUMNS), 8'd0, 8'h58);
		read_at(8'(COLUMNS - 1), 8'(ROWS - 1));
		// wrap on the last cell holds the cursor on the bottom row
		set_cursor(8'(COLUMNS - 1), 8'(ROWS - 1));
		put_ch(8'h5A);
		move_cursor(8'd76, 8'd0);
		put_ch(CH_TAB);
		put_ch(CH_LF);
		set_cursor(8'd0, 8'(ROWS));
		move_cursor(8'h80, 8'h80);
		move_cursor(8'd5, 8'hFD);
		move_cursor(8'hFA, 8'd0);
		send_any(CMD_SPARE6);
		send_any(CMD_SPARE7);
		send_any(CMD_CLEAR);
	endtask

	task automatic test_colour_registers();
		set_colours(4'h0, 4'hF);
		write_reg(REG_SPARE2, 4'h5);
		write_reg(REG_SPARE3, 4'hA);
		send_any(CMD_CLEAR);
		read_at(8'd5, 8'd5);
		put_cell(8'd0, 8'd0, 8'h41);
		read_at(8'd0, 8'd0);
	endtask

	task automatic send_random_cmd();
		logic [2:0] op;
		logic [7:0] chr;
		logic [7:0] c8;
		logic [7:0] r8;
		logic [7:0] dc;
		logic [7:0] dr;
		int pick;
		chr = 8'($urandom);
		c8 = 8'($urandom);
		r8 = 8'($urandom);
		dc = 8'($urandom);
		dr = 8'($urandom);
		pick = $urandom_range(0, 199);
		if (pick < 70) begin
			op = CMD_PUT_CUR;
			case ($urandom_range(0, 19))
				0: chr = CH_LF;
				1: chr = CH_CR;
				2: chr = CH_TAB;
				3: chr = 8'($urandom);
				default: chr = 8'($urandom_range(32, 127));
			endcase
		end else if (pick < 100) begin
			op = CMD_PUT_CELL;
			if ($urandom_range(0, 9) != 0) begin
				c8 = 8'($urandom_range(0, COLUMNS - 1));
				r8 = 8'($urandom_range(0, ROWS - 1));
			end
		end else if (pick < 120) begin
			op = CMD_SET_CUR;
			if ($urandom_range(0, 2) == 0) begin
				// near the bottom right, where wrap and tab clamp
				c8 = 8'($urandom_range(COLUMNS - 10, COLUMNS - 1));
				r8 = 8'(ROWS - 1);
			end else if ($urandom_range(0, 4) != 0) begin
				c8 = 8'($urandom_range(0, COLUMNS - 1));
				r8 = 8'($urandom_range(0, ROWS - 1));
			end
		end else if (pick < 145) begin
			op = CMD_MOVE_CUR;
			if ($urandom_range(0, 3) != 0) begin
				dc = 8'(int'($urandom_range(0, 6)) - 3);
				dr = 8'(int'($urandom_range(0, 4)) - 2);
			end
		end else if (pick < 190) begin
			op = CMD_READ;
			if ($urandom_range(0, 9) != 0) begin
				c8 = 8'($urandom_range(0, COLUMNS - 1));
				r8 = 8'($urandom_range(0, ROWS - 1));
			end
		end else if (pick < 197) begin
			op = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
		end else if (pick < 198) begin
			op = CMD_CLEAR;
		end else begin
			op = 3'($urandom);
		end
		send_cmd(op, chr, c8, r8, dc, dr);
	endtask

	task automatic test_random_traffic(int count, int gaps, int stalls);
		gap_pct = gaps;
		stall_pct = stalls;
		repeat (count)
			send_random_cmd();
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_FG;
		wr_data = '0;
		in_valid = 1'b0;
		cmd = CMD_PUT_CUR;
		ch = '0;
		col = '0;
		row = '0;
		col_step = '0;
		row_step = '0;
		out_ready = 1'b1;
		for (int i = 0; i < CELLS; i++)
			screen[i] = RESET_CELL;
		cur_c = 0;
		cur_r = 0;
		fg = RESET_FG;
		bg = RESET_BG;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_screen();
		test_put_at_cursor();
		test_cells_and_cursor();
		test_colour_registers();

		set_colours(4'($urandom), 4'($urandom));
		test_random_traffic(200, 20, 20);
		set_colours(4'h0, 4'h0);
		test_random_traffic(200, 0, 30);
		set_colours(4'hF, 4'hF);
		test_random_traffic(200, 30, 0);
		set_colours(4'($urandom), 4'($urandom));
		test_random_traffic(250, 15, 15);
		set_colours(RESET_FG, RESET_BG);
		test_random_traffic(200, 0, 0);

		wait_idle();
		repeat (10) @(posedge clk);
		$display("covered %0d commands with %0d clears and %0d register writes",
			n_cmds, n_clears, n_writes);
		$display("checked %0d results, %0d mismatches", n_checked, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb_text_console_cell_writer_top: done, clean");
		end else begin
			$display("tb_text_console_cell_writer_top: done, errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("tb_text_console_cell_writer_top: done, errors");
		$finish;
	end

endmodule

// File: text_console_cell_writer_top.f
rtl/tccw_pkg.sv
rtl/text_console_cell_writer_top.sv
tb/tb_text_console_cell_writer_top.sv
